// ----- hw/rtl/bop_pkg.sv -----
// Shared constants, codes and control types of the bencode object table parser.
package bop_pkg;

    localparam int MAX_DEPTH   = 16;
    localparam int INDEX_WIDTH = 16;
    localparam int POS_WIDTH   = 32;
    localparam int SP_W        = $clog2(MAX_DEPTH + 1);
    localparam int MA_W        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // Parse modes held between bytes.
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_LEN   = 3'd1;
    localparam logic [2:0] M_STR   = 3'd2;
    localparam logic [2:0] M_INT   = 3'd3;
    localparam logic [2:0] M_TAIL  = 3'd4;
    localparam logic [2:0] M_DRAIN = 3'd5;

    // Record kinds.
    localparam logic [1:0] K_NEW  = 2'd0;
    localparam logic [1:0] K_SIB  = 2'd1;
    localparam logic [1:0] K_CNT  = 2'd2;
    localparam logic [1:0] K_DONE = 2'd3;

    // Object types.
    localparam logic [1:0] T_TEXT = 2'd0;
    localparam logic [1:0] T_NUM  = 2'd1;
    localparam logic [1:0] T_LIST = 2'd2;
    localparam logic [1:0] T_DICT = 2'd3;

    // Record sources.
    localparam logic [2:0] R_PSIB = 3'd0;
    localparam logic [2:0] R_NEWS = 3'd1;
    localparam logic [2:0] R_NEWC = 3'd2;
    localparam logic [2:0] R_CNT  = 3'd3;
    localparam logic [2:0] R_KSIB = 3'd4;
    localparam logic [2:0] R_DONE = 3'd5;

    // Scalar size sources.
    localparam logic [1:0] S_TEXT0 = 2'd0;
    localparam logic [1:0] S_TEXTA = 2'd1;
    localparam logic [1:0] S_NUM   = 2'd2;

    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic                 load_in;
        logic                 clr_pend;
        logic                 emit;
        logic [2:0]           rsel;
        logic                 set_mode;
        logic [2:0]           mode_val;
        logic                 rem_inc;
        logic                 acc_digit;
        logic                 acc_first;
        logic                 set_start;
        logic                 load_left;
        logic                 dec_left;
        logic                 cnt_inc;
        logic                 cnt_clr;
        logic                 scal_set;
        logic [1:0]           scal_sel;
        logic                 obj_inc;
        logic                 push;
        logic                 pop;
        logic                 ed_obj;
        logic                 ed_top;
        logic                 set_want;
        logic                 child;
        logic                 set_pend;
        logic                 fail_zero;
        logic                 set_err;
        logic                 reload;
        logic                 pos_inc;
        logic                 reset_all;
        logic                 flush;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       is_digit;
        logic       is_colon;
        logic       is_e;
        logic       is_i;
        logic       is_ld;
        logic       is_minus;
        logic       last;
        logic       pend_valid;
        logic       acc_zero;
        logic       left_one;
        logic       cnt_zero;
        logic       sp_zero;
        logic       sp_full;
        logic       obj_full;
        logic       top_dict;
        logic       top_want;
        logic       slot_free;
    } t_stat;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] idx;
        logic [31:0]            count;
        logic                   is_dict;
        logic                   want;
    } t_frame;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] idx;
        logic [1:0]  otype;
        logic [31:0] offset;
        logic [31:0] size;
        logic [15:0] sib;
        logic [31:0] rem;
        logic        root;
        logic        err;
        logic        last;
    } t_rec;

endpackage

// ----- hw/rtl/bop_ctrl.sv -----
// Sequencing state machine: walks each byte through its parse steps.
module bop_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bop_pkg::t_stat i_st,
    output bop_pkg::t_cmd  o_cmd
);
    import bop_pkg::*;

    localparam logic [3:0] C_IDLE   = 4'd0;
    localparam logic [3:0] C_PEND   = 4'd1;
    localparam logic [3:0] C_MAIN   = 4'd2;
    localparam logic [3:0] C_SCAL   = 4'd3;
    localparam logic [3:0] C_CLOSE  = 4'd4;
    localparam logic [3:0] C_RLDE   = 4'd5;
    localparam logic [3:0] C_EDONE  = 4'd6;
    localparam logic [3:0] C_FAIL   = 4'd7;
    localparam logic [3:0] C_UNW    = 4'd8;
    localparam logic [3:0] C_RLDU   = 4'd9;
    localparam logic [3:0] C_UCHILD = 4'd10;
    localparam logic [3:0] C_POS    = 4'd11;
    localparam logic [3:0] C_DONE   = 4'd12;
    localparam logic [3:0] C_FLUSH  = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_fin, n_fin;
    logic       r_cont, n_cont;
    logic       key_ctx, list_ctx;

    assign key_ctx  = !i_st.sp_zero && i_st.top_dict && !i_st.top_want;
    assign list_ctx = !i_st.sp_zero && !i_st.top_dict;
    assign o_stall  = (r_state != C_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_cont  = r_cont;
        o_cmd   = '0;
        if (r_state == C_IDLE) begin
            if (i_valid) begin
                o_cmd.load_in = 1'b1;
                n_fin         = 1'b0;
                n_state       = C_PEND;
            end
        end else if (i_st.slot_free) begin
            case (r_state)
                C_PEND: begin
                    if (i_st.mode != M_DRAIN && i_st.pend_valid) begin
                        o_cmd.clr_pend = 1'b1;
                        if (!i_st.is_e) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.rsel = R_PSIB;
                        end
                    end
                    n_state = C_MAIN;
                end
                C_MAIN: begin
                    n_state = C_POS;
                    case (i_st.mode)
                        M_TAIL:  o_cmd.rem_inc = 1'b1;
                        M_DRAIN: n_state = C_POS;
                        M_LEN: begin
                            if (i_st.is_digit) begin
                                o_cmd.acc_digit = 1'b1;
                            end else if (i_st.is_colon) begin
                                o_cmd.set_start = 1'b1;
                                if (i_st.acc_zero) begin
                                    o_cmd.scal_set = 1'b1;
                                    o_cmd.scal_sel = S_TEXT0;
                                    n_state        = C_SCAL;
                                end else begin
                                    o_cmd.load_left = 1'b1;
                                    o_cmd.set_mode  = 1'b1;
                                    o_cmd.mode_val  = M_STR;
                                end
                            end else begin
                                n_state = C_FAIL;
                            end
                        end
                        M_STR: begin
                            o_cmd.dec_left = 1'b1;
                            if (i_st.left_one) begin
                                o_cmd.scal_set = 1'b1;
                                o_cmd.scal_sel = S_TEXTA;
                                n_state        = C_SCAL;
                            end
                        end
                        M_INT: begin
                            if (i_st.is_digit || (i_st.is_minus && i_st.cnt_zero)) begin
                                o_cmd.cnt_inc = 1'b1;
                            end else if (i_st.is_e) begin
                                o_cmd.scal_set = 1'b1;
                                o_cmd.scal_sel = S_NUM;
                                n_state        = C_SCAL;
                            end else begin
                                n_state = C_FAIL;
                            end
                        end
                        default: begin
                            // Start of a new element.
                            if (i_st.is_digit) begin
                                o_cmd.acc_first = 1'b1;
                                o_cmd.set_mode  = 1'b1;
                                o_cmd.mode_val  = M_LEN;
                            end else if (i_st.is_e && (key_ctx || list_ctx)) begin
                                n_state = C_CLOSE;
                            end else if (key_ctx) begin
                                n_state = C_FAIL;
                            end else if (i_st.is_i) begin
                                o_cmd.cnt_clr   = 1'b1;
                                o_cmd.set_start = 1'b1;
                                o_cmd.set_mode  = 1'b1;
                                o_cmd.mode_val  = M_INT;
                            end else if (i_st.is_ld) begin
                                if (i_st.sp_full || i_st.obj_full) begin
                                    n_state = C_FAIL;
                                end else begin
                                    o_cmd.emit     = 1'b1;
                                    o_cmd.rsel     = R_NEWC;
                                    o_cmd.obj_inc  = 1'b1;
                                    o_cmd.push     = 1'b1;
                                    o_cmd.set_mode = 1'b1;
                                    o_cmd.mode_val = M_IDLE;
                                end
                            end else begin
                                n_state = C_FAIL;
                            end
                        end
                    endcase
                end
                C_SCAL: begin
                    if (i_st.obj_full) begin
                        n_state = C_FAIL;
                    end else begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.rsel    = R_NEWS;
                        o_cmd.ed_obj  = 1'b1;
                        o_cmd.obj_inc = 1'b1;
                        n_cont        = 1'b0;
                        n_state       = C_EDONE;
                    end
                end
                C_CLOSE: begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.rsel   = R_CNT;
                    o_cmd.ed_top = 1'b1;
                    o_cmd.pop    = 1'b1;
                    n_cont       = 1'b1;
                    n_state      = C_RLDE;
                end
                C_RLDE: begin
                    o_cmd.reload = 1'b1;
                    n_state      = C_EDONE;
                end
                C_EDONE: begin
                    o_cmd.set_mode = 1'b1;
                    o_cmd.mode_val = M_IDLE;
                    if (i_st.sp_zero) begin
                        o_cmd.mode_val = M_TAIL;
                        o_cmd.set_pend = r_cont;
                    end else if (i_st.top_dict && !i_st.top_want) begin
                        o_cmd.set_want = 1'b1;
                    end else begin
                        o_cmd.child    = 1'b1;
                        o_cmd.set_pend = 1'b1;
                        if (i_st.top_dict && i_st.top_want) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.rsel = R_KSIB;
                        end
                    end
                    n_state = C_POS;
                end
                C_FAIL: begin
                    o_cmd.fail_zero = 1'b1;
                    o_cmd.set_err   = 1'b1;
                    n_state         = C_UNW;
                end
                C_UNW: begin
                    if (!i_st.sp_zero) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.rsel   = R_CNT;
                        o_cmd.ed_top = 1'b1;
                        o_cmd.pop    = 1'b1;
                        n_state      = C_RLDU;
                    end else begin
                        o_cmd.clr_pend = 1'b1;
                        o_cmd.set_mode = 1'b1;
                        o_cmd.mode_val = M_DRAIN;
                        n_state        = r_fin ? C_DONE : C_POS;
                    end
                end
                C_RLDU: begin
                    o_cmd.reload = 1'b1;
                    n_state      = C_UCHILD;
                end
                C_UCHILD: begin
                    if (!i_st.sp_zero) begin
                        o_cmd.child = 1'b1;
                        if (i_st.top_dict && i_st.top_want) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.rsel = R_KSIB;
                        end
                    end
                    n_state = C_UNW;
                end
                C_POS: begin
                    o_cmd.pos_inc = 1'b1;
                    if (!i_st.last) begin
                        n_state = C_FLUSH;
                    end else if (i_st.mode != M_TAIL && i_st.mode != M_DRAIN) begin
                        n_fin   = 1'b1;
                        n_state = C_FAIL;
                    end else begin
                        n_state = C_DONE;
                    end
                end
                C_DONE: begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.rsel      = R_DONE;
                    o_cmd.reset_all = 1'b1;
                    n_state         = C_FLUSH;
                end
                C_FLUSH: begin
                    o_cmd.flush = 1'b1;
                    n_state     = C_IDLE;
                end
                default: n_state = C_IDLE;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_fin   <= 1'b0;
            r_cont  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_cont  <= n_cont;
        end
    end

`ifndef SYNTH
    a_fin_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_POS && !i_st.last && i_st.slot_free) |=> (r_state == C_FLUSH))
        else $error("byte without end mark did not go to flush");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_IDLE && i_valid) |=> (r_state == C_PEND))
        else $error("accepted item did not start processing");
    a_done_then_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_DONE && i_st.slot_free) |=> (r_state == C_FLUSH))
        else $error("done record not followed by flush");
`endif

endmodule

// ----- hw/rtl/bop_dp.sv -----
// Datapath: parse registers, container stack memory and record staging.
module bop_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bop_pkg::t_cmd  i_cmd,
    output bop_pkg::t_stat o_st,
    input  logic [7:0]     i_in_byte,
    input  logic           i_last_byte,
    input  logic           i_stall,
    output logic           o_valid,
    output bop_pkg::t_rec  o_rec
);
    import bop_pkg::*;

    logic [7:0]             r_byte;
    logic                   r_last;
    logic [2:0]             r_mode;
    logic [POS_WIDTH-1:0]   r_pos;
    logic [31:0]            r_acc;
    logic [31:0]            r_left;
    logic [31:0]            r_cnt;
    logic [INDEX_WIDTH:0]   r_obj;
    logic [SP_W-1:0]        r_sp;
    logic                   r_pv;
    logic [INDEX_WIDTH-1:0] r_pidx;
    logic [31:0]            r_rem;
    logic                   r_err;
    logic [POS_WIDTH-1:0]   r_start;
    logic [1:0]             r_styp;
    logic [31:0]            r_ssize;
    logic [INDEX_WIDTH-1:0] r_ed;
    t_frame                 r_top;
    t_frame                 r_rd;
    t_frame                 mem [MAX_DEPTH];
    t_rec                   r_hold;
    logic                   r_hv;
    t_rec                   r_out;
    logic                   r_ov;

    logic [3:0]             digit;
    logic [35:0]            acc_next;
    logic [SP_W-1:0]        sp_m1, sp_m2;
    logic [INDEX_WIDTH-1:0] obj_idx;
    logic                   slot_free;
    t_rec                   rec;
    t_rec                   hold_last;

    assign digit     = 4'(r_byte - CH_ZERO);
    assign acc_next  = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + 36'(digit);
    assign sp_m1     = r_sp - SP_W'(1);
    assign sp_m2     = r_sp - SP_W'(2);
    assign obj_idx   = r_obj[INDEX_WIDTH-1:0];
    assign slot_free = !r_ov || !i_stall;

    // Status towards the controller.
    always_comb begin
        o_st.mode       = r_mode;
        o_st.is_digit   = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
        o_st.is_colon   = (r_byte == CH_COLON);
        o_st.is_e       = (r_byte == CH_E);
        o_st.is_i       = (r_byte == CH_I);
        o_st.is_ld      = (r_byte == CH_L) || (r_byte == CH_D);
        o_st.is_minus   = (r_byte == CH_MINUS);
        o_st.last       = r_last;
        o_st.pend_valid = r_pv;
        o_st.acc_zero   = (r_acc == '0);
        o_st.left_one   = (r_left == 32'd1);
        o_st.cnt_zero   = (r_cnt == '0);
        o_st.sp_zero    = (r_sp == '0);
        o_st.sp_full    = (r_sp == SP_W'(MAX_DEPTH));
        o_st.obj_full   = r_obj[INDEX_WIDTH];
        o_st.top_dict   = r_top.is_dict;
        o_st.top_want   = r_top.want;
        o_st.slot_free  = slot_free;
    end

    // Record assembly for the selected source.
    always_comb begin
        rec = '0;
        case (i_cmd.rsel)
            R_PSIB: begin
                rec.kind = K_SIB;
                rec.idx  = 16'(r_pidx);
                rec.sib  = 16'(obj_idx - r_pidx);
            end
            R_NEWS: begin
                rec.kind   = K_NEW;
                rec.idx    = 16'(obj_idx);
                rec.otype  = r_styp;
                rec.offset = 32'(r_start);
                rec.size   = r_ssize;
            end
            R_NEWC: begin
                rec.kind  = K_NEW;
                rec.idx   = 16'(obj_idx);
                rec.otype = (r_byte == CH_D) ? T_DICT : T_LIST;
            end
            R_CNT: begin
                rec.kind  = K_CNT;
                rec.idx   = 16'(r_top.idx);
                rec.otype = r_top.is_dict ? T_DICT : T_LIST;
                rec.size  = r_top.count;
            end
            R_KSIB: begin
                rec.kind = K_SIB;
                rec.idx  = 16'(r_ed - INDEX_WIDTH'(1));
                rec.sib  = 16'd1;
            end
            R_DONE: begin
                rec.kind = K_DONE;
                rec.rem  = (r_mode == M_TAIL && !r_err) ? r_rem : 32'd0;
                rec.root = (r_obj != '0);
                rec.err  = r_err;
            end
            default: rec = '0;
        endcase
    end

    // Staged record marked as the final one of its byte.
    always_comb begin
        hold_last      = r_hold;
        hold_last.last = 1'b1;
    end

    // Stack memory: written on push, read at the new top on pop.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_sp != '0) begin
            mem[sp_m1[MA_W-1:0]] <= r_top;
        end
        if (i_cmd.pop) begin
            r_rd <= mem[sp_m2[MA_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_in_byte;
            r_last <= i_last_byte;
        end
        if (i_cmd.acc_first) begin
            r_acc <= 32'(digit);
        end else if (i_cmd.acc_digit) begin
            r_acc <= (acc_next[35:32] != 4'd0) ? '1 : acc_next[31:0];
        end else if (i_cmd.reset_all) begin
            r_acc <= '0;
        end
        if (i_cmd.load_left) begin
            r_left <= r_acc;
        end else if (i_cmd.dec_left) begin
            r_left <= r_left - 32'd1;
        end else if (i_cmd.reset_all) begin
            r_left <= '0;
        end
        if (i_cmd.cnt_clr || i_cmd.reset_all) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc && r_cnt != '1) begin
            r_cnt <= r_cnt + 32'd1;
        end
        if (i_cmd.set_start) begin
            r_start <= r_pos + POS_WIDTH'(1);
        end
        if (i_cmd.scal_set) begin
            case (i_cmd.scal_sel)
                S_TEXTA: begin
                    r_styp  <= T_TEXT;
                    r_ssize <= r_acc;
                end
                S_NUM: begin
                    r_styp  <= T_NUM;
                    r_ssize <= r_cnt;
                end
                default: begin
                    r_styp  <= T_TEXT;
                    r_ssize <= '0;
                end
            endcase
        end
        if (i_cmd.ed_obj) begin
            r_ed <= obj_idx;
        end else if (i_cmd.ed_top) begin
            r_ed <= r_top.idx;
        end
        if (i_cmd.set_pend) begin
            r_pidx <= r_ed;
        end
        // Top of stack held in registers.
        if (i_cmd.push) begin
            r_top.idx     <= obj_idx;
            r_top.count   <= '0;
            r_top.is_dict <= (r_byte == CH_D);
            r_top.want    <= 1'b0;
        end else if (i_cmd.reload) begin
            if (r_sp != '0) begin
                r_top <= r_rd;
            end
        end else if (i_cmd.set_want) begin
            r_top.want <= 1'b1;
        end else if (i_cmd.child) begin
            if (r_top.count != '1) begin
                r_top.count <= r_top.count + 32'd1;
            end
            if (r_top.is_dict && r_top.want) begin
                r_top.want <= 1'b0;
            end
        end else if (i_cmd.fail_zero) begin
            if (r_sp != '0 && r_top.is_dict && r_top.want) begin
                r_top.count <= '0;
            end
        end
        if (i_cmd.emit) begin
            r_hold <= rec;
        end
        if (i_cmd.emit && r_hv) begin
            r_out <= r_hold;
        end else if (i_cmd.flush && r_hv) begin
            r_out <= hold_last;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos  <= '0;
            r_obj  <= '0;
            r_sp   <= '0;
            r_pv   <= 1'b0;
            r_rem  <= '0;
            r_err  <= 1'b0;
            r_hv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cmd.reset_all) begin
                r_mode <= M_IDLE;
                r_pos  <= '0;
                r_obj  <= '0;
                r_sp   <= '0;
                r_pv   <= 1'b0;
                r_rem  <= '0;
                r_err  <= 1'b0;
            end else begin
                if (i_cmd.set_mode) begin
                    r_mode <= i_cmd.mode_val;
                end
                if (i_cmd.pos_inc) begin
                    r_pos <= r_pos + POS_WIDTH'(1);
                end
                if (i_cmd.obj_inc) begin
                    r_obj <= r_obj + (INDEX_WIDTH + 1)'(1);
                end
                if (i_cmd.push) begin
                    r_sp <= r_sp + SP_W'(1);
                end else if (i_cmd.pop) begin
                    r_sp <= sp_m1;
                end
                if (i_cmd.set_pend) begin
                    r_pv <= 1'b1;
                end else if (i_cmd.clr_pend) begin
                    r_pv <= 1'b0;
                end
                if (i_cmd.rem_inc && r_rem != '1) begin
                    r_rem <= r_rem + 32'd1;
                end
                if (i_cmd.set_err) begin
                    r_err <= 1'b1;
                end
            end
            // Output stage: staged record moves out when a newer one arrives or at flush.
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if ((i_cmd.emit || i_cmd.flush) && r_hv) begin
                r_ov <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_hv <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hv <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_rec   = r_out;

`ifndef SYNTH
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(MAX_DEPTH))
        else $error("stack pointer beyond depth");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_sp != SP_W'(MAX_DEPTH)))
        else $error("push with a full stack");
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_hv) |-> slot_free)
        else $error("record moved out over a stalled record");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_sp != '0))
        else $error("pop with an empty stack");
`endif

endmodule

// ----- hw/rtl/bencode_object_table_parser_top.sv -----
// Top level of the bencode object table parser.
//
// Input channel: i_valid, o_stall, i_in_byte, i_last_byte. One item is one byte
// of a bencoded buffer; i_last_byte marks the final byte.
// Output channel: o_valid, i_stall and the record fields. Each byte yields zero or
// more records; o_last_record marks the final record caused by that byte.
// Every buffer closes with a done record, after which the parser is back in its
// reset state for the next buffer.
// A byte that completes nothing passes the accept, sibling check, parse, position
// update and flush steps before the next acceptance. Completing a scalar adds the
// scalar record and completion steps, closing a container the close, stack memory
// read and completion steps. An error adds fail and unwind steps plus close, stack
// memory read and child steps per open container; the done record on the last byte
// adds its own step. One step per cycle while no stalled record blocks the output.
// Records pass through a staging register and an output register: a record moves
// out when the next record of its byte is made, the final one at the flush step.
// Reset (synchronous, active low) clears the parse state and empties the output.
// While i_stall holds a waiting record, the output holds and the parser pauses.
module bencode_object_table_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_record_kind,
    output logic [15:0] o_object_index,
    output logic [1:0]  o_object_type,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_data_size,
    output logic [15:0] o_sibling_offset,
    output logic [31:0] o_remaining_bytes,
    output logic        o_root_present,
    output logic        o_parse_error,
    output logic        o_last_record
);
    import bop_pkg::*;

    t_cmd cmd;
    t_stat st;
    t_rec rec;

    bop_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    bop_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_in_byte   (i_in_byte),
        .i_last_byte (i_last_byte),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_rec       (rec)
    );

    // Record fields onto their ports.
    assign o_record_kind     = rec.kind;
    assign o_object_index    = rec.idx;
    assign o_object_type     = rec.otype;
    assign o_data_offset     = rec.offset;
    assign o_data_size       = rec.size;
    assign o_sibling_offset  = rec.sib;
    assign o_remaining_bytes = rec.rem;
    assign o_root_present    = rec.root;
    assign o_parse_error     = rec.err;
    assign o_last_record     = rec.last;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench of the bencode object table parser, with its own record predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bop_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DEPTH_MAX      = 16;
    localparam int OBJ_LIMIT      = 65536;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] idx;
        logic [1:0]  otype;
        logic [31:0] offset;
        logic [31:0] size;
        logic [15:0] sib;
        logic [31:0] rem;
        logic        root;
        logic        err;
        logic        last;
    } t_exp_rec;

    typedef struct {
        int unsigned idx;
        logic [31:0] count;
        bit          is_dict;
        bit          want;
    } t_model_frame;

    typedef enum int {PS_IDLE, PS_LEN, PS_STR, PS_INT, PS_TAIL, PS_DRAIN} t_pmode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_in_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_record_kind;
    logic [15:0] o_object_index;
    logic [1:0]  o_object_type;
    logic [31:0] o_data_offset;
    logic [31:0] o_data_size;
    logic [15:0] o_sibling_offset;
    logic [31:0] o_remaining_bytes;
    logic        o_root_present;
    logic        o_parse_error;
    logic        o_last_record;

    bencode_object_table_parser_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    t_model_frame open_frames[DEPTH_MAX];
    t_pmode      pmode;
    logic [31:0] byte_pos, len_acc, str_left, num_chars, tail_count, scal_start;
    int unsigned obj_count, depth, pend_idx;
    bit          pend_on, err_seen;

    t_exp_rec expected_records[$];
    t_exp_rec step_recs[$];
    int   n_errors = 0, n_checked = 0, n_bytes = 0, n_buffers = 0;
    bit   calm = 0;
    int   idle_cycles = 0;
    int   idle_cycles_wd = 0;

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void push_rec(logic [1:0] k, int unsigned ix, logic [1:0] t,
                                     logic [31:0] off, logic [31:0] sz, int unsigned sb,
                                     logic [31:0] rm, logic rt, logic er);
        t_exp_rec r;
        r.kind = k; r.idx = ix[15:0]; r.otype = t; r.offset = off; r.size = sz;
        r.sib = sb[15:0]; r.rem = rm; r.root = rt; r.err = er; r.last = 1'b0;
        step_recs = {step_recs, r};
    endfunction

    function automatic void parser_clear();
        pmode = PS_IDLE; byte_pos = 0; len_acc = 0; str_left = 0; num_chars = 0;
        obj_count = 0; depth = 0; pend_on = 0; pend_idx = 0; tail_count = 0;
        err_seen = 0; scal_start = 0;
    endfunction

    function automatic void count_child(int f, int unsigned child);
        if (open_frames[f].count != '1) open_frames[f].count++;
        if (open_frames[f].is_dict && open_frames[f].want) begin
            push_rec(K_SIB, child - 1, T_TEXT, 0, 0, 1, 0, 0, 0);
            open_frames[f].want = 0;
        end
    endfunction

    function automatic void close_all();
        t_model_frame f;
        while (depth > 0) begin
            depth--;
            f = open_frames[depth];
            push_rec(K_CNT, f.idx, f.is_dict ? T_DICT : T_LIST, 0, f.count, 0, 0, 0, 0);
            if (depth > 0) count_child(depth - 1, f.idx);
        end
        pend_on = 0;
    endfunction

    function automatic void abort_element();
        if (depth > 0 && open_frames[depth-1].is_dict && open_frames[depth-1].want)
            open_frames[depth-1].count = 0;
        err_seen = 1;
        close_all();
        pmode = PS_DRAIN;
    endfunction

    function automatic void finish_element(int unsigned ix, bit container);
        pmode = PS_IDLE;
        if (depth == 0) begin
            pmode = PS_TAIL;
            if (container) begin
                pend_on = 1; pend_idx = ix;
            end
            return;
        end
        if (open_frames[depth-1].is_dict && !open_frames[depth-1].want) begin
            open_frames[depth-1].want = 1;
            return;
        end
        count_child(depth - 1, ix);
        pend_on = 1; pend_idx = ix;
    endfunction

    function automatic void finish_scalar(logic [1:0] t, logic [31:0] sz);
        int unsigned ix;
        if (obj_count >= OBJ_LIMIT) begin
            abort_element();
            return;
        end
        ix = obj_count++;
        push_rec(K_NEW, ix, t, scal_start, sz, 0, 0, 0, 0);
        finish_element(ix, 0);
    endfunction

    function automatic void begin_element(logic [7:0] b, logic [31:0] pos);
        bit key_ctx = 0, list_ctx = 0;
        t_model_frame f;
        int unsigned ix;
        if (depth > 0) begin
            key_ctx = open_frames[depth-1].is_dict && !open_frames[depth-1].want;
            list_ctx = !open_frames[depth-1].is_dict;
        end
        if (is_digit(b)) begin
            len_acc = b - CH_ZERO; pmode = PS_LEN;
        end else if (b == CH_E && (key_ctx || list_ctx)) begin
            depth--;
            f = open_frames[depth];
            push_rec(K_CNT, f.idx, f.is_dict ? T_DICT : T_LIST, 0, f.count, 0, 0, 0, 0);
            finish_element(f.idx, 1);
        end else if (key_ctx) begin
            abort_element();
        end else if (b == CH_I) begin
            num_chars = 0; scal_start = pos + 1; pmode = PS_INT;
        end else if (b == CH_L || b == CH_D) begin
            if (depth >= DEPTH_MAX || obj_count >= OBJ_LIMIT) begin
                abort_element();
                return;
            end
            ix = obj_count++;
            push_rec(K_NEW, ix, b == CH_D ? T_DICT : T_LIST, 0, 0, 0, 0, 0, 0);
            open_frames[depth].idx = ix;
            open_frames[depth].count = 0;
            open_frames[depth].is_dict = (b == CH_D);
            open_frames[depth].want = 0;
            depth++;
            pmode = PS_IDLE;
        end else begin
            abort_element();
        end
    endfunction

    // Works out every record one byte causes and queues them.
    function automatic void predict_byte(logic [7:0] b, logic last);
        logic [31:0] pos = byte_pos;
        logic [31:0] rm;
        step_recs.delete();
        if (pmode != PS_DRAIN && pend_on) begin
            if (b != CH_E) push_rec(K_SIB, pend_idx, T_TEXT, 0, 0, obj_count - pend_idx, 0, 0, 0);
            pend_on = 0;
        end
        case (pmode)
            PS_TAIL: if (tail_count != '1) tail_count++;
            PS_DRAIN: ;
            PS_LEN: begin
                if (is_digit(b)) begin
                    if (len_acc > (32'hFFFF_FFFF - (b - CH_ZERO)) / 10) len_acc = '1;
                    else len_acc = len_acc * 10 + (b - CH_ZERO);
                end else if (b == CH_COLON) begin
                    scal_start = pos + 1;
                    if (len_acc == 0) finish_scalar(T_TEXT, 0);
                    else begin
                        str_left = len_acc; pmode = PS_STR;
                    end
                end else abort_element();
            end
            PS_STR: begin
                str_left--;
                if (str_left == 0) finish_scalar(T_TEXT, len_acc);
            end
            PS_INT: begin
                if (is_digit(b) || (b == CH_MINUS && num_chars == 0)) begin
                    if (num_chars != '1) num_chars++;
                end else if (b == CH_E) finish_scalar(T_NUM, num_chars);
                else abort_element();
            end
            default: begin_element(b, pos);
        endcase
        byte_pos = pos + 1;
        if (last) begin
            if (pmode != PS_TAIL && pmode != PS_DRAIN) abort_element();
            rm = (pmode == PS_TAIL && !err_seen) ? tail_count : 32'd0;
            push_rec(K_DONE, 0, T_TEXT, 0, 0, 0, rm, obj_count > 0, err_seen);
            parser_clear();
        end
        if (step_recs.size() > 0) step_recs[step_recs.size()-1].last = 1'b1;
        expected_records = {expected_records, step_recs};
    endfunction

    // Sends one byte, with a random gap before it unless in the calm stretch.
    task automatic send_byte(logic [7:0] b, logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(b, last);
        n_bytes++;
        if (last) n_buffers++;
    endtask

    task automatic send_buffer(string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_records.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Receiver stall in random bursts.
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) i_stall <= 1'b0;
        else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            idle_cycles <= $urandom_range(0, 7);
            i_stall <= 1'b1;
        end else i_stall <= 1'b0;
    end

    // Compares each accepted record with the oldest expected one.
    always @(posedge i_clk) begin
        t_exp_rec e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_records.size() == 0) begin
                $error("record with none expected: kind %0d", o_record_kind);
                n_errors++;
            end else begin
                e = expected_records.pop_front();
                n_checked++;
                if (o_record_kind !== e.kind) begin
                    $error("record_kind exp %0d got %0d", e.kind, o_record_kind); n_errors++;
                end
                if (o_object_index !== e.idx) begin
                    $error("object_index exp %0d got %0d", e.idx, o_object_index); n_errors++;
                end
                if (o_object_type !== e.otype) begin
                    $error("object_type exp %0d got %0d", e.otype, o_object_type); n_errors++;
                end
                if (o_data_offset !== e.offset) begin
                    $error("data_offset exp %0d got %0d", e.offset, o_data_offset); n_errors++;
                end
                if (o_data_size !== e.size) begin
                    $error("data_size exp %0d got %0d", e.size, o_data_size); n_errors++;
                end
                if (o_sibling_offset !== e.sib) begin
                    $error("sibling_offset exp %0d got %0d", e.sib, o_sibling_offset);
                    n_errors++;
                end
                if (o_remaining_bytes !== e.rem) begin
                    $error("remaining_bytes exp %0d got %0d", e.rem, o_remaining_bytes);
                    n_errors++;
                end
                if (o_root_present !== e.root) begin
                    $error("root_present exp %0d got %0d", e.root, o_root_present); n_errors++;
                end
                if (o_parse_error !== e.err) begin
                    $error("parse_error exp %0d got %0d", e.err, o_parse_error); n_errors++;
                end
                if (o_last_record !== e.last) begin
                    $error("last_record exp %0d got %0d", e.last, o_last_record); n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles_wd <= 0;
        else if (i_rst_n) idle_cycles_wd <= idle_cycles_wd + 1;
        if (idle_cycles_wd >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic string random_scalar();
        string s = "";
        int n;
        if ($urandom_range(0, 1)) begin
            n = $urandom_range(0, 6);
            s = $sformatf("%0d:", n);
            repeat (n) s = {s, string'(8'($urandom_range(0, 255)))};
        end else begin
            s = "i";
            if ($urandom_range(0, 2) == 0) s = {s, "-"};
            repeat ($urandom_range(0, 5)) s = {s, string'(8'($urandom_range(48, 57)))};
            s = {s, "e"};
        end
        return s;
    endfunction

    function automatic string random_value(int lvl);
        string s;
        int n;
        if (lvl >= 4 || $urandom_range(0, 2) == 0) return random_scalar();
        n = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) begin
            s = "l";
            repeat (n) s = {s, random_value(lvl + 1)};
        end else begin
            s = "d";
            repeat (n) s = {s, $sformatf("%0d:k", 1), random_value(lvl + 1)};
        end
        return {s, "e"};
    endfunction

    task automatic test_directed();
        send_buffer("4:spam");
        send_buffer("i-42e");
        send_buffer("ie");
        send_buffer("i-e");
        send_buffer("0:");
        send_buffer("le");
        send_buffer("d3:keyi1e1:al1:xee");
        send_buffer("li1ei2eeXY");
    endtask

    task automatic test_errors();
        send_buffer("d1:ae");
        send_buffer("di1ee");
        send_buffer("i1-e");
        send_buffer("4a:");
        send_buffer("l4:ab");
        send_buffer("x");
        send_buffer("99999999999:");
        send_buffer("lllllllllllllllllle");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_pause();
        send_buffer("ll1:aei7ee");
        wait_drained();
    endtask

    task automatic test_random(int target);
        string s;
        int start = n_bytes;
        while (n_bytes - start < target) begin
            s = random_value(0);
            if ($urandom_range(0, 5) == 0) s = {s, random_scalar()};
            if ($urandom_range(0, 7) == 0 && s.len() > 1) s = s.substr(0, s.len() - 2);
            if ($urandom_range(0, 9) == 0) s[$urandom_range(0, s.len() - 1)] =
                8'($urandom_range(0, 255));
            if (n_bytes - start > target * 3 / 4) calm = 1;
            send_buffer(s);
        end
    endtask

    initial begin
        parser_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_errors();
        test_pause();
        test_random(166);
        wait_drained();
        $display("Covered %0d bytes in %0d buffers, %0d records checked.",
                 n_bytes, n_buffers, n_checked);
        if (n_errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end
endmodule
